@@ rtl/periodic_job_timer_table_defines.svh @@
// Assertion macros shared by the timer table RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PERIODIC_JOB_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_JOB_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PJTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PJTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pjtt_pkg.sv @@
// Types and constants for the periodic job timer table.
// No dependencies; used by pjtt_mem and periodic_job_timer_table.
`timescale 1ns / 1ps

package pjtt_pkg;

  localparam int Slots  = 8;
  localparam int SlotW  = 3;
  localparam int CountW = 16;
  localparam int JobW   = 8;
  localparam int FuncW  = 2;
  localparam int KindW  = 2;

  // Request codes
  localparam logic [FuncW-1:0] FUNC_TICK     = 2'd0;
  localparam logic [FuncW-1:0] FUNC_REGISTER = 2'd1;
  localparam logic [FuncW-1:0] FUNC_REMOVE   = 2'd2;

  // Result codes
  localparam logic [KindW-1:0] KIND_EXPIRED    = 2'd0;
  localparam logic [KindW-1:0] KIND_REGISTERED = 2'd1;
  localparam logic [KindW-1:0] KIND_FULL       = 2'd2;
  localparam logic [KindW-1:0] KIND_REMOVED    = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [CountW-1:0] period;
    logic [JobW-1:0]   job_id;
    logic [SlotW-1:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] slot_index;
    logic [JobW-1:0]  job_tag;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] period;
    logic [CountW-1:0] count;
    logic [JobW-1:0]   job;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

@@ rtl/pjtt_mem.sv @@
// Slot table memory: period, countdown and job id per slot.
// One write and one registered read per cycle. Depends on pjtt_pkg.
`timescale 1ns / 1ps

module pjtt_mem (
  input  logic               clk_i,
  input  pjtt_pkg::mem_req_t req_i,
  output pjtt_pkg::entry_t   rd_data_o
);

  pjtt_pkg::entry_t mem_q [pjtt_pkg::Slots];
  pjtt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    // Hold read data while no read is issued
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/periodic_job_timer_table.sv @@
// Top level of the periodic job timer table: request sequencer, active flags,
// result staging. Depends on pjtt_pkg, pjtt_mem and the assertion macro header.
`timescale 1ns / 1ps

// Eight periodic timer slots. A register request claims the lowest free slot
// and answers with its number (or "table full"); a remove request frees a slot
// and is always acknowledged; a tick counts every active slot down and reports
// each slot that reaches zero, in slot order, with last set on the final one.
// One request is handled at a time. The slot memory has one read port, so the
// tick sweep reads, updates and writes back one slot per cycle, unless a stall
// holds it while an expiry waits on the result side. The table is empty right
// after reset; no clearing pass is needed. A new request is taken while the
// last result still waits in the output register.
module periodic_job_timer_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pjtt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pjtt_pkg::out_item_t out_item_o
);

`include "periodic_job_timer_table_defines.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_RMV   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [pjtt_pkg::Slots-1:0]   active_q, active_d;
  logic [pjtt_pkg::SlotW-1:0]   idx_q, idx_d;
  logic                         pend_v_q, pend_v_d;
  pjtt_pkg::out_item_t          pend_q, pend_d;
  logic                         out_v_q, out_v_d;
  pjtt_pkg::out_item_t          out_q, out_d;

  pjtt_pkg::mem_req_t           mem_req;
  pjtt_pkg::entry_t             rd_data;

  logic                         in_acc;
  logic                         out_free;
  logic                         free_found;
  logic [pjtt_pkg::SlotW-1:0]   free_idx;
  logic                         cur_act;
  logic [pjtt_pkg::CountW-1:0]  cnt_dec;
  logic                         expire;
  logic                         stall;

  pjtt_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pjtt_pkg::Slots - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = pjtt_pkg::SlotW'(i);
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_v_q || out_ready_i;

  assign cur_act = active_q[idx_q];
  assign cnt_dec = rd_data.count - pjtt_pkg::CountW'(1);
  assign expire  = cur_act && (cnt_dec == '0);
  // An expiry must push the held result out before taking its place
  assign stall   = expire && pend_v_q && !out_free;

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    idx_d    = idx_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    mem_req  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_item_i.func)
            pjtt_pkg::FUNC_TICK: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = '0;
              idx_d           = '0;
              state_d         = S_SWEEP;
            end
            pjtt_pkg::FUNC_REGISTER: begin
              if (free_found) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = free_idx;
                mem_req.wr_data = '{period: in_item_i.period,
                                    count:  in_item_i.period,
                                    job:    in_item_i.job_id};
                active_d[free_idx] = 1'b1;
                pend_d = '{kind: pjtt_pkg::KIND_REGISTERED, slot_index: free_idx,
                           job_tag: in_item_i.job_id, last: 1'b1};
              end else begin
                pend_d = '{kind: pjtt_pkg::KIND_FULL, slot_index: '0,
                           job_tag: '0, last: 1'b1};
              end
              pend_v_d = 1'b1;
              state_d  = S_FLUSH;
            end
            pjtt_pkg::FUNC_REMOVE: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = in_item_i.slot;
              idx_d           = in_item_i.slot;
              state_d         = S_RMV;
            end
            default: begin
              // unused code: drop the transaction
            end
          endcase
        end
      end

      S_SWEEP: begin
        if (!stall) begin
          if (cur_act) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_q;
            mem_req.wr_data = '{period: rd_data.period,
                                count:  expire ? rd_data.period : cnt_dec,
                                job:    rd_data.job};
          end
          if (expire) begin
            if (pend_v_q) begin
              out_v_d      = 1'b1;
              out_d        = pend_q;
              out_d.last   = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = '{kind: pjtt_pkg::KIND_EXPIRED, slot_index: idx_q,
                         job_tag: rd_data.job, last: 1'b1};
          end
          if (idx_q == pjtt_pkg::SlotW'(pjtt_pkg::Slots - 1)) begin
            state_d = S_FLUSH;
          end else begin
            // advance to the next slot
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_q + 1'b1;
            idx_d           = idx_q + 1'b1;
          end
        end
      end

      S_RMV: begin
        pend_d = '{kind: pjtt_pkg::KIND_REMOVED, slot_index: idx_q,
                   job_tag: cur_act ? rd_data.job : '0, last: 1'b1};
        active_d[idx_q] = 1'b0;
        pend_v_d        = 1'b1;
        state_d         = S_FLUSH;
      end

      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d  = 1'b1;
          out_d    = pend_q;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  `PJTT_ASSERT_SAME(a_no_rw_same_slot, mem_req.rd_en && mem_req.wr_en,
                    mem_req.rd_addr != mem_req.wr_addr, "read and write hit the same slot")
  `PJTT_ASSERT_NEXT(a_register_claims_one,
                    in_acc && (in_item_i.func == pjtt_pkg::FUNC_REGISTER) && free_found,
                    $countones(active_q) == $countones($past(active_q)) + 1,
                    "register did not claim exactly one slot")
  `PJTT_ASSERT_NEXT(a_flush_drains, (state_q == S_FLUSH) && (state_d == S_IDLE),
                    !pend_v_q, "held result left behind after flush")
  `PJTT_ASSERT_SAME(a_idle_nothing_held, state_q == S_IDLE, !pend_v_q,
                    "held result present while idle")

endmodule

@@ dv/periodic_job_timer_table_tb.sv @@
// Self-checking testbench for periodic_job_timer_table: directed and random requests,
// a timer-table predictor and an in-order result scoreboard. Depends on pjtt_pkg.
`timescale 1ns / 1ps

module periodic_job_timer_table_tb;

  localparam logic [pjtt_pkg::FuncW-1:0] FUNC_RESERVED = 2'd3;
  localparam int HoldCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  pjtt_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pjtt_pkg::out_item_t out_item_o;

  // Predicted table contents
  bit [pjtt_pkg::Slots-1:0]    table_active = '0;
  logic [pjtt_pkg::CountW-1:0] table_period [pjtt_pkg::Slots];
  logic [pjtt_pkg::CountW-1:0] table_count [pjtt_pkg::Slots];
  logic [pjtt_pkg::JobW-1:0]   table_job [pjtt_pkg::Slots];

  pjtt_pkg::out_item_t expected_results[$];
  pjtt_pkg::out_item_t got, want;
  int        error_count = 0;
  bit        no_idle = 1'b0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  periodic_job_timer_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pjtt_pkg::in_item_t make_request(logic [pjtt_pkg::FuncW-1:0] f,
                                                      logic [pjtt_pkg::CountW-1:0] p,
                                                      logic [pjtt_pkg::JobW-1:0] j,
                                                      logic [pjtt_pkg::SlotW-1:0] s);
    pjtt_pkg::in_item_t req;
    req.func   = f;
    req.period = p;
    req.job_id = j;
    req.slot   = s;
    return req;
  endfunction

  function automatic pjtt_pkg::out_item_t make_result(logic [pjtt_pkg::KindW-1:0] k,
                                                      logic [pjtt_pkg::SlotW-1:0] idx,
                                                      logic [pjtt_pkg::JobW-1:0] tag,
                                                      logic lst);
    pjtt_pkg::out_item_t res;
    res.kind       = k;
    res.slot_index = idx;
    res.job_tag    = tag;
    res.last       = lst;
    return res;
  endfunction

  // Update the predicted table for one accepted request and queue its results.
  task automatic apply_timer_request(input pjtt_pkg::in_item_t req);
    bit [pjtt_pkg::Slots-1:0]  fired;
    int                        last_fired;
    int                        free_slot;
    logic [pjtt_pkg::JobW-1:0] tag;
    fired      = '0;
    last_fired = -1;
    free_slot  = -1;
    tag        = '0;
    case (req.func)
      pjtt_pkg::FUNC_TICK: begin
        for (int i = 0; i < pjtt_pkg::Slots; i++) begin
          if (table_active[i]) begin
            table_count[i] = table_count[i] - 1'b1;
            if (table_count[i] == '0) begin
              table_count[i] = table_period[i];
              fired[i]       = 1'b1;
              last_fired     = i;
            end
          end
        end
        for (int i = 0; i < pjtt_pkg::Slots; i++) begin
          if (fired[i]) begin
            expected_results.push_back(make_result(pjtt_pkg::KIND_EXPIRED,
                                                   pjtt_pkg::SlotW'(i), table_job[i],
                                                   i == last_fired));
          end
        end
      end
      pjtt_pkg::FUNC_REGISTER: begin
        for (int i = pjtt_pkg::Slots - 1; i >= 0; i--) begin
          if (!table_active[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          expected_results.push_back(make_result(pjtt_pkg::KIND_FULL, '0, '0, 1'b1));
        end else begin
          table_active[free_slot] = 1'b1;
          table_period[free_slot] = req.period;
          table_count[free_slot]  = req.period;
          table_job[free_slot]    = req.job_id;
          expected_results.push_back(make_result(pjtt_pkg::KIND_REGISTERED,
                                                 pjtt_pkg::SlotW'(free_slot),
                                                 req.job_id, 1'b1));
        end
      end
      pjtt_pkg::FUNC_REMOVE: begin
        if (table_active[req.slot]) begin
          tag = table_job[req.slot];
          table_active[req.slot] = 1'b0;
        end
        expected_results.push_back(make_result(pjtt_pkg::KIND_REMOVED, req.slot, tag,
                                               1'b1));
      end
      default: begin
        // reserved code: no result, no state change
      end
    endcase
  endtask

  task automatic send_request(input pjtt_pkg::in_item_t req);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 29) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    apply_timer_request(req);
  endtask

  // Drop valid and hold off until every predicted result has come out.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic test_directed();
    send_request(make_request(pjtt_pkg::FUNC_TICK, '0, '0, '0));
    send_request(make_request(FUNC_RESERVED, 16'hFFFF, 8'hFF, 3'd7));
    send_request(make_request(pjtt_pkg::FUNC_REMOVE, '0, '0, 3'd0));
    send_request(make_request(pjtt_pkg::FUNC_REMOVE, '0, '0, 3'd7));
    // fill all eight slots, period extremes included
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd1, 8'h00, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd1, 8'hFF, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd2, 8'hA5, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd3, 8'h5A, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'hFFFF, 8'h01, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'h0000, 8'h80, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd1, 8'h3C, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd1, 8'hC3, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd5, 8'h77, '0));
    repeat (3) send_request(make_request(pjtt_pkg::FUNC_TICK, '0, '0, '0));
    send_request(make_request(pjtt_pkg::FUNC_REMOVE, '0, '0, 3'd4));
    send_request(make_request(pjtt_pkg::FUNC_REMOVE, '0, '0, 3'd5));
    send_request(make_request(pjtt_pkg::FUNC_REMOVE, '0, '0, 3'd4));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd1, 8'h11, '0));
    send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'd1, 8'h22, '0));
    // the third of these ticks expires every slot at once
    repeat (3) send_request(make_request(pjtt_pkg::FUNC_TICK, '0, '0, '0));
  endtask

  task automatic test_random_mix(input int n_items);
    pjtt_pkg::in_item_t req;
    int       done;
    int       choice;
    int       s;
    done = 0;
    while (done < n_items) begin
      req.period = 16'($urandom_range(0, 65535));
      req.job_id = 8'($urandom_range(0, 255));
      req.slot   = 3'($urandom_range(0, 7));
      choice     = $urandom_range(0, 99);
      if (choice < 3) begin
        req.func = FUNC_RESERVED;
      end else if (choice < 50) begin
        req.func = pjtt_pkg::FUNC_TICK;
      end else if (choice < 75) begin
        req.func = pjtt_pkg::FUNC_REGISTER;
        s = $urandom_range(0, 9);
        if (s < 7) req.period = 16'($urandom_range(1, 6));
        else if (s == 7) req.period = '0;
      end else begin
        req.func = pjtt_pkg::FUNC_REMOVE;
        // mostly free a slot that is in use
        if ($urandom_range(0, 4) != 0 && table_active != '0) begin
          s = $urandom_range(0, pjtt_pkg::Slots - 1);
          while (!table_active[s]) s = (s + 1) % pjtt_pkg::Slots;
          req.slot = pjtt_pkg::SlotW'(s);
        end
      end
      send_request(req);
      if (req.func != FUNC_RESERVED) done++;
    end
  endtask

  task automatic test_backpressure();
    no_idle       <= 1'b1;
    hold_requests <= hold_requests + 1;
    for (int s = 0; s < pjtt_pkg::Slots; s++) begin
      send_request(make_request(pjtt_pkg::FUNC_REMOVE, '0, '0, pjtt_pkg::SlotW'(s)));
    end
    for (int k = 0; k < 22; k++) begin
      if (k % 3 == 0) begin
        send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'($urandom_range(1, 2)),
                                  8'($urandom_range(0, 255)), '0));
      end else begin
        send_request(make_request(pjtt_pkg::FUNC_TICK, '0, '0, '0));
      end
    end
    no_idle <= 1'b0;
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) begin
        send_request(make_request(pjtt_pkg::FUNC_REGISTER, 16'($urandom_range(1, 3)),
                                  8'($urandom_range(0, 255)), '0));
      end else begin
        send_request(make_request(pjtt_pkg::FUNC_TICK, '0, '0, '0));
      end
      wait_for_results();
    end
  endtask

  task automatic test_no_idle();
    no_idle <= 1'b1;
    test_random_mix(60);
    no_idle <= 1'b0;
  endtask

  // Receiver: random stalls except while no_idle is set, and a long hold-off on request that applies even then.
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 29);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_item_o;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d slot %0d tag %0h last %0b", $time,
                 got.kind, got.slot_index, got.job_tag, got.last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
          error_count++;
        end
        if (got.slot_index !== want.slot_index) begin
          $display("%0t: slot_index expected %0d got %0d", $time, want.slot_index,
                   got.slot_index);
          error_count++;
        end
        if (got.job_tag !== want.job_tag) begin
          $display("%0t: job_tag expected %0h got %0h", $time, want.job_tag, got.job_tag);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix(140);
    test_backpressure();
    test_sender_pause();
    test_no_idle();
    test_random_mix(70);
    wait_for_results();
    // leave room for a late spurious result
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ periodic_job_timer_table.f @@
+incdir+rtl
rtl/pjtt_pkg.sv
rtl/pjtt_mem.sv
rtl/periodic_job_timer_table.sv
dv/periodic_job_timer_table_tb.sv
